### hw/rtl/cylinder_mesh_generator_top_defines.svh
// Assertion macros for the checker file of the cylinder mesh block.
`ifndef CYLINDER_MESH_GENERATOR_TOP_DEFINES_SVH
`define CYLINDER_MESH_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, switched off while reset is high.
`define CMG_ASSERT_HOLDS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cylinder mesh checker: property failed");

// Next-cycle implication that is also checked across reset.
`define CMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("cylinder mesh checker: property failed");

`endif

### hw/rtl/cmg_pkg.sv
package cmg_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int CORDIC_STEPS = 16;
  localparam int SEG_W  = 9;
  localparam int FRAC_W = 16;
  localparam int QUOT_W = FRAC_W + 1;
  localparam int ZW     = 34;

  localparam logic signed [ZW-1:0] CORDIC_GAIN = ZW'(652032874);
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [15:0] ONE_Q14 = 16'sd16384;

  localparam logic [1:0] PH_SIDE    = 2'd0;
  localparam logic [1:0] PH_CAP_TRI = 2'd1;
  localparam logic [1:0] PH_CAP_VTX = 2'd2;

  localparam logic [1:0] CFG_RADIUS   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_SEGMENTS = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

  function automatic logic signed [ZW-1:0] atan_q30(input logic [4:0] k);
    logic signed [ZW-1:0] v;
    case (k)
      5'd0:  v = ZW'(843314857);
      5'd1:  v = ZW'(497837829);
      5'd2:  v = ZW'(263043837);
      5'd3:  v = ZW'(133525159);
      5'd4:  v = ZW'(67021687);
      5'd5:  v = ZW'(33543516);
      5'd6:  v = ZW'(16775851);
      5'd7:  v = ZW'(8388437);
      5'd8:  v = ZW'(4194283);
      5'd9:  v = ZW'(2097149);
      5'd10: v = ZW'(1048576);
      5'd11: v = ZW'(524288);
      5'd12: v = ZW'(262144);
      5'd13: v = ZW'(131072);
      5'd14: v = ZW'(65536);
      5'd15: v = ZW'(32768);
      5'd16: v = ZW'(16384);
      5'd17: v = ZW'(8192);
      5'd18: v = ZW'(4096);
      5'd19: v = ZW'(2048);
      5'd20: v = ZW'(1024);
      5'd21: v = ZW'(512);
      5'd22: v = ZW'(256);
      5'd23: v = ZW'(128);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/cmg_div.sv
module cmg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [cmg_pkg::SEG_W-1:0]     numer,
  input  logic [cmg_pkg::SEG_W-1:0]     denom,
  output cmg_pkg::unit_status_t         status,
  output logic [cmg_pkg::QUOT_W-1:0]    quot
);
  import cmg_pkg::*;

  logic [SEG_W-1:0] rem;
  logic [SEG_W-1:0] dv;
  logic [4:0]       cnt;
  logic [SEG_W:0]   rem_sh;
  logic [SEG_W:0]   rem_sub;
  logic             take;

  // Numerator never exceeds the divisor, so the integer part is a single bit.
  assign rem_sh  = {rem, 1'b0};
  assign take    = rem_sh >= {1'b0, dv};
  assign rem_sub = rem_sh - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      cnt    <= '0;
    end else begin
      status.done <= status.busy && !start && (cnt == 5'(FRAC_W - 1));
      if (start) begin
        status.busy <= 1'b1;
        cnt         <= '0;
        dv          <= denom;
        quot        <= {(numer >= denom), {FRAC_W{1'b0}}};
        rem         <= (numer >= denom) ? SEG_W'(numer - denom) : numer;
      end else if (status.busy) begin
        rem                <= take ? rem_sub[SEG_W-1:0] : rem_sh[SEG_W-1:0];
        quot[FRAC_W-1:0]   <= {quot[FRAC_W-2:0], take};
        cnt                <= cnt + 5'd1;
        if (cnt == 5'(FRAC_W - 1)) begin
          status.busy <= 1'b0;
        end
      end
    end
  end

endmodule

### hw/rtl/cmg_cordic.sv
module cmg_cordic (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [15:0]           turn,
  output cmg_pkg::unit_status_t status,
  output logic signed [15:0]    sin_q14,
  output logic signed [15:0]    cos_q14
);
  import cmg_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_ZLOAD, C_ITER, C_ROUND} cstate_t;

  localparam logic signed [ZW-1:0] ONE_W  = ZW'(16384);
  localparam logic signed [ZW-1:0] HALF_W = ZW'(32768);

  cstate_t              state;
  logic [13:0]          ang;
  logic [1:0]           quad;
  logic signed [ZW-1:0] x, y, z;
  logic [4:0]           k;
  logic [44:0]          zprod;
  logic signed [ZW-1:0] dx, dy;
  logic signed [15:0]   s, c;

  function automatic logic signed [15:0] to_q14(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] r;
    r = (v + HALF_W) >>> 16;
    if (r > ONE_W)       return ONE_Q14;
    else if (r < -ONE_W) return -ONE_Q14;
    else                 return r[15:0];
  endfunction

  assign zprod = ang * HALF_PI_Q30;
  assign dx    = y >>> k;
  assign dy    = x >>> k;
  assign s     = to_q14(y);
  assign c     = to_q14(x);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= C_IDLE;
      status <= '0;
      k      <= '0;
    end else begin
      status.done <= (state == C_ROUND);
      case (state)
        C_IDLE: begin
          if (start) begin
            ang         <= turn[13:0];
            quad        <= turn[15:14];
            status.busy <= 1'b1;
            state       <= C_ZLOAD;
          end
        end
        C_ZLOAD: begin
          z     <= ZW'(zprod >> 14);
          x     <= CORDIC_GAIN;
          y     <= '0;
          k     <= '0;
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[ZW-1]) begin
            x <= x - dx;
            y <= y + dy;
            z <= z - atan_q30(k);
          end else begin
            x <= x + dx;
            y <= y - dy;
            z <= z + atan_q30(k);
          end
          k <= k + 5'd1;
          if (k == 5'(CORDIC_STEPS - 1)) state <= C_ROUND;
        end
        C_ROUND: begin
          // Fold the first-quadrant result out to the quadrant of the turn.
          case (quad)
            2'd0: begin sin_q14 <= s;  cos_q14 <= c;  end
            2'd1: begin sin_q14 <= c;  cos_q14 <= -s; end
            2'd2: begin sin_q14 <= -s; cos_q14 <= -c; end
            default: begin sin_q14 <= -c; cos_q14 <= s; end
          endcase
          status.busy <= 1'b0;
          state       <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/cylinder_mesh_generator_top.sv
// Channel  | Handshake               | Payload
// config   | cfg_we                  | cfg_index, cfg_data
// input    | in_valid / in_ready     | restart
// output   | out_valid / out_ready   | record_kind, pos_*, norm_*, tex_*, vertex_index,
//          |                         | last_record
// An index record goes from acceptance through S_FIN into the output register once that register is free.
// A vertex record reaches it after 16 divider steps, 16 CORDIC steps, an angle load,
// a rounding step, a multiply and the hand-over and load steps between them.
// One transaction is in work at a time; in_ready is high only while the sequencer idles.
// The output register lets the next input transaction be taken while a result waits.
// Synchronous reset returns the mesh to its first record and the registers to defaults.
module cylinder_mesh_generator_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [9:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               restart,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               record_kind,
  output logic signed [24:0] pos_x,
  output logic [23:0]        pos_y,
  output logic signed [24:0] pos_z,
  output logic signed [15:0] norm_x,
  output logic signed [15:0] norm_y,
  output logic signed [15:0] norm_z,
  output logic [16:0]        tex_u,
  output logic [16:0]        tex_v,
  output logic [9:0]         vertex_index,
  output logic               last_record
);
  import cmg_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_CORDIC, S_MUL, S_FIN} seq_state_t;

  seq_state_t         state;
  logic [9:0]         cylinder_radius;
  logic [9:0]         cylinder_height;
  logic [SEG_W-1:0]   segment_count;
  logic [1:0]         mesh_phase;
  logic [SEG_W-1:0]   slice_counter;
  logic [2:0]         record_in_slice;

  logic               w_vertex;
  logic [1:0]         w_phase;
  logic [2:0]         w_rec;
  logic [9:0]         w_vidx;
  logic               w_last;
  logic signed [24:0] px_r, pz_r;

  logic [SEG_W-1:0]   t;
  logic [9:0]         m;
  logic [1:0]         n_phase;
  logic [SEG_W-1:0]   n_i;
  logic [2:0]         n_rec;
  logic [1:0]         mesh_phase_next;
  logic [SEG_W-1:0]   slice_counter_next;
  logic [2:0]         record_in_slice_next;
  logic               n_vertex;
  logic               n_last;
  logic [9:0]         n_vidx;
  logic               accept;
  logic               load_out;

  unit_status_t       div_st, cor_st;
  logic [QUOT_W-1:0]  quot;
  logic signed [15:0] sn, cs;
  logic signed [26:0] px_full, pz_full;
  logic [17:0]        cap_u, cap_v;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign load_out = (state == S_FIN) && (!out_valid || out_ready);

  assign t = (segment_count < SEG_W'(3)) ? SEG_W'(3) :
             (segment_count > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS) : segment_count;
  assign m = {t, 1'b0} + 10'd2;

  always_comb begin
    logic [9:0] a, a2, a3, i1;
    n_phase = mesh_phase;
    n_i     = slice_counter;
    n_rec   = record_in_slice;
    if (restart || mesh_phase > PH_CAP_VTX) begin
      n_phase = PH_SIDE; n_i = '0; n_rec = '0;
    end
    if (n_phase == PH_SIDE && n_i > t) begin
      n_phase = PH_CAP_TRI; n_i = '0; n_rec = '0;
    end
    if (n_phase == PH_CAP_TRI && n_rec > 3'd2) n_rec = '0;
    if (n_phase == PH_CAP_TRI && n_i >= t - SEG_W'(2)) begin
      n_phase = PH_CAP_VTX; n_i = '0; n_rec = '0;
    end
    if (n_phase == PH_CAP_VTX && n_i >= t) begin
      n_phase = PH_SIDE; n_i = '0; n_rec = '0;
    end

    a  = {n_i, 1'b0};
    a2 = a + 10'd2;
    a3 = a + 10'd3;
    if (a2 >= m) a2 = a2 - m;
    if (a3 >= m) a3 = a3 - m;
    i1 = {1'b0, n_i} + 10'd1;

    n_vertex = (n_phase == PH_SIDE && n_rec < 3'd2) || (n_phase == PH_CAP_VTX);
    n_last   = (n_phase == PH_CAP_VTX) && (i1 >= {1'b0, t});
    n_vidx   = '0;
    mesh_phase_next      = n_phase;
    slice_counter_next   = n_i;
    record_in_slice_next = n_rec + 3'd1;

    case (n_phase)
      PH_SIDE: begin
        case (n_rec)
          3'd2:    n_vidx = a + 10'd1;
          3'd3:    n_vidx = a2;
          3'd4:    n_vidx = a;
          3'd5:    n_vidx = a3;
          3'd6:    n_vidx = a2;
          default: n_vidx = a + 10'd1;
        endcase
        if (n_rec == 3'd7) begin
          record_in_slice_next = '0;
          if (n_i >= t) begin
            mesh_phase_next = PH_CAP_TRI; slice_counter_next = '0;
          end else begin
            slice_counter_next = i1[SEG_W-1:0];
          end
        end
      end
      PH_CAP_TRI: begin
        case (n_rec)
          3'd0:    n_vidx = m;
          3'd1:    n_vidx = m + i1 + 10'd1;
          default: n_vidx = m + i1;
        endcase
        if (n_rec >= 3'd2) begin
          record_in_slice_next = '0;
          if (i1 >= {1'b0, t} - 10'd2) begin
            mesh_phase_next = PH_CAP_VTX; slice_counter_next = '0;
          end else begin
            slice_counter_next = i1[SEG_W-1:0];
          end
        end
      end
      default: begin
        record_in_slice_next = '0;
        if (n_last) begin
          mesh_phase_next = PH_SIDE; slice_counter_next = '0;
        end else begin
          slice_counter_next = i1[SEG_W-1:0];
        end
      end
    endcase
  end

  cmg_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (accept && n_vertex),
    .numer  (n_i),
    .denom  (t),
    .status (div_st),
    .quot   (quot)
  );

  cmg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (div_st.done),
    .turn    (quot[FRAC_W-1:0]),
    .status  (cor_st),
    .sin_q14 (sn),
    .cos_q14 (cs)
  );

  assign px_full = $signed({1'b0, cylinder_radius}) * sn;
  assign pz_full = $signed({1'b0, cylinder_radius}) * cs;
  assign cap_u   = 18'd32768 + {sn[15], sn, 1'b0};
  assign cap_v   = 18'd32768 - {cs[15], cs, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      out_valid       <= 1'b0;
      cylinder_radius <= 10'd1;
      cylinder_height <= 10'd1;
      segment_count   <= SEG_W'(16);
      mesh_phase      <= PH_SIDE;
      slice_counter   <= '0;
      record_in_slice <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_RADIUS:   cylinder_radius <= cfg_data;
          CFG_HEIGHT:   cylinder_height <= cfg_data;
          CFG_SEGMENTS: segment_count   <= cfg_data[SEG_W-1:0];
          default: ;
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            mesh_phase      <= mesh_phase_next;
            slice_counter   <= slice_counter_next;
            record_in_slice <= record_in_slice_next;
            w_vertex        <= n_vertex;
            w_phase         <= n_phase;
            w_rec           <= n_rec;
            w_vidx          <= n_vidx;
            w_last          <= n_last;
            state           <= n_vertex ? S_DIV : S_FIN;
          end
        end
        S_DIV:    if (div_st.done) state <= S_CORDIC;
        S_CORDIC: if (cor_st.done) state <= S_MUL;
        S_MUL: begin
          px_r  <= px_full[24:0];
          pz_r  <= pz_full[24:0];
          state <= S_FIN;
        end
        S_FIN: begin
          if (load_out) begin
            last_record <= w_last;
            if (w_vertex) begin
              record_kind  <= 1'b0;
              vertex_index <= '0;
              pos_x        <= px_r;
              pos_z        <= pz_r;
              if (w_phase == PH_SIDE) begin
                pos_y  <= (w_rec == 3'd0) ? {cylinder_height, 14'd0} : 24'd0;
                norm_x <= sn;
                norm_y <= '0;
                norm_z <= cs;
                tex_u  <= 17'd65536 - quot;
                tex_v  <= (w_rec == 3'd0) ? 17'd0 : 17'd65536;
              end else begin
                pos_y  <= {cylinder_height, 14'd0};
                norm_x <= '0;
                norm_y <= ONE_Q14;
                norm_z <= '0;
                tex_u  <= cap_u[16:0];
                tex_v  <= cap_v[16:0];
              end
            end else begin
              record_kind  <= 1'b1;
              vertex_index <= w_vidx;
              pos_x        <= '0;
              pos_y        <= '0;
              pos_z        <= '0;
              norm_x       <= '0;
              norm_y       <= '0;
              norm_z       <= '0;
              tex_u        <= '0;
              tex_v        <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### hw/rtl/cmg_checker.sv
`include "cylinder_mesh_generator_top_defines.svh"

module cmg_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic               record_kind,
  input logic [23:0]        pos_y,
  input logic signed [15:0] norm_x,
  input logic signed [15:0] norm_y,
  input logic [9:0]         vertex_index,
  input logic               last_record
);

  `CMG_ASSERT_NEXT(a_rst_clears_out, rst, !out_valid)
  `CMG_ASSERT_HOLDS(a_out_held, out_valid && !out_ready, ##1 out_valid)
  `CMG_ASSERT_HOLDS(a_index_clean, out_valid && record_kind, ~|pos_y && !last_record)
  `CMG_ASSERT_HOLDS(a_vertex_clean, out_valid && !record_kind, vertex_index == 0)
  `CMG_ASSERT_HOLDS(a_last_is_cap, out_valid && last_record, norm_y == 16'sd16384 && ~|norm_x)

endmodule

bind cylinder_mesh_generator_top cmg_checker u_cmg_checker (.*);

### test/cylinder_mesh_generator_top_test.sv
`timescale 1ns / 100ps

module cylinder_mesh_generator_top_test;
  import cmg_pkg::*;

  typedef struct packed {
    logic               kind;
    logic signed [24:0] px;
    logic [23:0]        py;
    logic signed [24:0] pz;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic [16:0]        tu;
    logic [16:0]        tv;
    logic [9:0]         vidx;
    logic               last;
  } mesh_record_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [9:0]         cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               restart;
  logic               out_valid;
  logic               out_ready;
  logic               record_kind;
  logic signed [24:0] pos_x;
  logic [23:0]        pos_y;
  logic signed [24:0] pos_z;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;
  logic [16:0]        tex_u;
  logic [16:0]        tex_v;
  logic [9:0]         vertex_index;
  logic               last_record;

  cylinder_mesh_generator_top DUT (.*);

  // Predictor state and its copy of the registers.
  int unsigned  radius_q, height_q, segments_q;
  int unsigned  phase_q, slice_q, rec_q;
  mesh_record_t expected_records[$];
  bit           pending_restarts[$];
  int           stall_hold;
  int           mismatches;
  int           received;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fshift(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint round_q14(longint v);
    longint r;
    r = fshift(v + (64'sd1 << 15), 16);
    if (r > 16384) r = 16384;
    if (r < -16384) r = -16384;
    return r;
  endfunction

  task automatic enqueue_restart(input bit rs);
    pending_restarts = {pending_restarts, rs};
  endtask

  task automatic sin_cos(input int unsigned i, input int unsigned t,
                         output longint sn, output longint cs);
    longint unsigned quot;
    int unsigned     f, q;
    longint          x, y, z, dx, dy, s, c;
    quot = (longint'(i) << 16) / t;
    f = 32'(quot & 64'hFFFF);
    q = f >> 14;
    z = ((longint'(f & 32'h3FFF)) * longint'(HALF_PI_Q30)) >>> 14;
    x = 652032874;
    y = 0;
    for (int k = 0; k < CORDIC_STEPS && k < 24; k++) begin
      dx = fshift(y, k);
      dy = fshift(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(atan_q30(k[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(atan_q30(k[4:0]));
      end
    end
    s = round_q14(y);
    c = round_q14(x);
    case (q)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = -s; end
      2: begin sn = -s; cs = -c; end
      default: begin sn = -c; cs = s; end
    endcase
  endtask

  task automatic predict_record(input bit rs, output mesh_record_t r);
    int unsigned t, m, i, rc, a;
    longint      sn, cs;
    t = segments_q;
    if (t < 3) t = 3;
    if (t > MAX_SEGMENTS) t = MAX_SEGMENTS;
    m = 2 * (t + 1);
    r = '0;
    if (rs || phase_q > 2) begin
      phase_q = PH_SIDE; slice_q = 0; rec_q = 0;
    end
    if (phase_q == PH_SIDE && slice_q > t) begin
      phase_q = PH_CAP_TRI; slice_q = 0; rec_q = 0;
    end
    if (phase_q == PH_CAP_TRI && rec_q > 2) rec_q = 0;
    if (phase_q == PH_CAP_TRI && slice_q >= t - 2) begin
      phase_q = PH_CAP_VTX; slice_q = 0; rec_q = 0;
    end
    if (phase_q == PH_CAP_VTX && slice_q >= t) begin
      phase_q = PH_SIDE; slice_q = 0; rec_q = 0;
    end
    i = slice_q;
    rc = rec_q;
    if (phase_q == PH_SIDE) begin
      if (rc < 2) begin
        sin_cos(i, t, sn, cs);
        r.px = 25'(longint'(radius_q) * sn);
        r.pz = 25'(longint'(radius_q) * cs);
        r.py = (rc == 0) ? 24'(height_q << 14) : 24'd0;
        r.nx = 16'(sn);
        r.nz = 16'(cs);
        r.tu = 17'(65536 - ((longint'(i) << 16) / t));
        r.tv = (rc == 0) ? 17'd0 : 17'd65536;
      end else begin
        a = 2 * i;
        r.kind = 1'b1;
        case (rc)
          2: r.vidx = 10'(a + 1);
          3: r.vidx = 10'((a + 2) % m);
          4: r.vidx = 10'(a);
          5: r.vidx = 10'((a + 3) % m);
          6: r.vidx = 10'((a + 2) % m);
          default: r.vidx = 10'(a + 1);
        endcase
      end
      if (rc >= 7) begin
        rec_q = 0;
        if (i >= t) begin
          phase_q = PH_CAP_TRI; slice_q = 0;
        end else slice_q = (i + 1) & 9'h1FF;
      end else rec_q = rc + 1;
    end else if (phase_q == PH_CAP_TRI) begin
      r.kind = 1'b1;
      r.vidx = 10'((rc == 0) ? m : (rc == 1) ? m + i + 2 : m + i + 1);
      if (rc >= 2) begin
        rec_q = 0;
        if (i + 1 >= t - 2) begin
          phase_q = PH_CAP_VTX; slice_q = 0;
        end else slice_q = (i + 1) & 9'h1FF;
      end else rec_q = rc + 1;
    end else begin
      sin_cos(i, t, sn, cs);
      r.px = 25'(longint'(radius_q) * sn);
      r.pz = 25'(longint'(radius_q) * cs);
      r.py = 24'(height_q << 14);
      r.ny = ONE_Q14;
      r.tu = 17'(32768 + 2 * sn);
      r.tv = 17'(32768 - 2 * cs);
      rec_q = 0;
      if (i + 1 >= t) begin
        r.last = 1'b1;
        phase_q = PH_SIDE; slice_q = 0;
      end else slice_q = (i + 1) & 9'h1FF;
    end
  endtask

  // Driver: offers each queued restart flag after a random gap.
  int in_gap;
  always @(posedge clk) begin
    mesh_record_t r;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap <= int'($urandom_range(0, 10));
    end else if (in_valid && !in_ready) begin
    end else if (in_valid && in_ready && (pending_restarts.size() == 0 || in_gap > 0)) begin
      predict_record(restart, r);
      expected_records = {expected_records, r};
      in_valid <= 1'b0;
    end else if (in_gap > 0 && !(in_valid && in_ready)) begin
      in_gap <= in_gap - 1;
    end else begin
      if (in_valid && in_ready) begin
        predict_record(restart, r);
        expected_records = {expected_records, r};
      end
      if (pending_restarts.size() > 0) begin
        restart <= pending_restarts.pop_front();
        in_valid <= 1'b1;
        in_gap <= ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 10));
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random back-pressure, plus an occasional long hold-off.
  int out_gap;
  always @(posedge clk) begin
    mesh_record_t e;
    mesh_record_t got;
    if (rst) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got = '{record_kind, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
                tex_u, tex_v, vertex_index, last_record};
        received++;
        if (expected_records.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Unexpected record: %p", got);
        end else begin
          e = expected_records.pop_front();
          if (got !== e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("Record mismatch: expected %p, actual %p", e, got);
          end
        end
        out_gap <= ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(0, 10));
      end
      if (stall_hold > 0) begin
        stall_hold <= stall_hold - 1;
        out_ready <= 1'b0;
      end else if (out_valid && out_ready) begin
        out_ready <= 1'b0;
      end else if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 10'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_RADIUS:   radius_q = value & 10'h3FF;
      CFG_HEIGHT:   height_q = value & 10'h3FF;
      default:      segments_q = value & 9'h1FF;
    endcase
  endtask

  task automatic drain;
    while (pending_restarts.size() > 0 || in_valid || expected_records.size() > 0)
      @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  initial begin
    int unsigned seg_set[8];
    seg_set = '{16, 3, 256, 0, 511, 4, 7, 5};
    cfg_we = 1'b0; cfg_index = CFG_RADIUS; cfg_data = '0;
    in_valid = 1'b0; restart = 1'b0; out_ready = 1'b0;
    radius_q = 1; height_q = 1; segments_q = 16;
    phase_q = PH_SIDE; slice_q = 0; rec_q = 0;
    stall_hold = 0; mismatches = 0; received = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: part of a default mesh, a restart mid-mesh, and a long hold-off.
    for (int k = 0; k < 20; k++) enqueue_restart(k == 12);
    stall_hold = 300;
    drain();
    // Register extremes: small meshes, largest and then zero radius and height.
    write_reg(CFG_RADIUS, 1023);
    write_reg(CFG_HEIGHT, 1023);
    write_reg(CFG_SEGMENTS, 3);
    for (int k = 0; k < 25; k++) enqueue_restart(1'b0);
    drain();
    write_reg(CFG_RADIUS, 0);
    write_reg(CFG_HEIGHT, 0);
    write_reg(CFG_SEGMENTS, 2);
    for (int k = 0; k < 10; k++) enqueue_restart(1'b0);
    drain();

    // Random phases over several settings; restarts are rare.
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_RADIUS, (p % 3 == 0) ? 1023 : $urandom_range(0, 1023));
      write_reg(CFG_HEIGHT, (p % 3 == 1) ? 1023 : $urandom_range(0, 1023));
      write_reg(CFG_SEGMENTS, (p == 2) ? 256 : seg_set[p]);
      for (int k = 0; k < (p == 2 ? 60 : 190); k++)
        enqueue_restart($urandom_range(0, 40) == 0);
      if (p == 4) stall_hold = 400;
      drain();
    end

    if (mismatches == 0 && expected_records.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
